// File: design/stereo_feedback_delay_unit_defines.svh
// Assertion macros shared by the RTL files.
// SFD_ASSERT_IMP checks the consequent in the same cycle, SFD_ASSERT_NXT in the cycle after.
// Both expect signals named clk and rst in the module that uses them.
`ifndef STEREO_FEEDBACK_DELAY_UNIT_DEFINES_SVH
`define STEREO_FEEDBACK_DELAY_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define SFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SFD_ASSERT_IMP(lbl, ante, cons, msg)
`define SFD_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: design/sfd_pkg.sv
`timescale 1ns / 1ps
package sfd_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int MAX_DELAY_DEF   = 262144;

  localparam int DELAY_MS_W  = 11;
  localparam int RATE_W      = 17;
  localparam int FB_W        = 15;
  localparam int WET_W       = 16;
  localparam int CFG_DATA_W  = 17;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_MS    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_RATE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FEEDBACK    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_WET_MIX     = 3'd3;

  localparam logic [DELAY_MS_W-1:0] DELAY_MS_RST = 11'd500;
  localparam logic [DELAY_MS_W-1:0] DELAY_MS_MIN = 11'd1;
  localparam logic [DELAY_MS_W-1:0] DELAY_MS_MAX = 11'd2000;
  localparam logic [RATE_W-1:0]     RATE_RST     = 17'd48000;
  localparam logic [FB_W-1:0]       FB_RST       = 15'd16384;
  localparam logic [FB_W-1:0]       FB_MAX       = 15'd31129;
  localparam logic [WET_W-1:0]      WET_RST      = 16'd16384;
  localparam logic [WET_W-1:0]      WET_MAX      = 16'd32768;
  localparam logic [WET_W:0]        Q15_ONE      = 17'd32768;

  // Cycles from a register write until the delay length is valid again.
  localparam int SETTLE_CYCLES  = 4;
  localparam int OUT_FIFO_DEPTH = 8;

  typedef struct packed {
    logic [FB_W-1:0]  fb;
    logic [WET_W-1:0] wet;
  } gain_t;

endpackage

// File: design/sfd_ram.sv
`timescale 1ns / 1ps
module sfd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/sfd_delay_calc.sv
`timescale 1ns / 1ps
module sfd_delay_calc #(
  parameter int MAX_DELAY = sfd_pkg::MAX_DELAY_DEF,
  localparam int AW = $clog2(MAX_DELAY)
) (
  input  logic                            clk,
  input  logic [sfd_pkg::DELAY_MS_W-1:0] delay_ms,
  input  logic [sfd_pkg::RATE_W-1:0]     sample_rate_hz,
  output logic [AW-1:0]                   delay
);

  localparam int PW        = sfd_pkg::DELAY_MS_W + sfd_pkg::RATE_W;
  localparam int RECIP_W   = 29;
  localparam int DIV_SHIFT = 38;
  localparam int QW        = 19;
  localparam int CW        = (AW > QW) ? AW : QW;
  // floor(2^38 / 1000): the estimate is low by at most one
  localparam logic [RECIP_W-1:0] DIV_RECIP = 29'd274877906;
  localparam logic [9:0]         DIVISOR   = 10'd1000;

  logic [PW-1:0]         prod;
  logic [PW-1:0]         prod_d;
  logic [PW-1:0]         prod_dd;
  logic [PW+RECIP_W-1:0] scaled;
  logic [QW-1:0]         q_est;
  logic [PW-1:0]         q_back;
  logic [PW-1:0]         rem;
  logic [QW-1:0]         q_fix;
  logic [CW-1:0]         q_clamp;

  always_ff @(posedge clk) begin
    prod    <= PW'(delay_ms) * PW'(sample_rate_hz);
    prod_d  <= prod;
    scaled  <= (PW+RECIP_W)'(prod) * (PW+RECIP_W)'(DIV_RECIP);
    prod_dd <= prod_d;
    q_est   <= scaled[DIV_SHIFT +: QW];
    q_back  <= PW'(scaled[DIV_SHIFT +: QW]) * PW'(DIVISOR);
    delay   <= AW'(q_clamp);
  end

  always_comb begin
    rem   = prod_dd - q_back;
    q_fix = q_est + QW'(rem >= PW'(DIVISOR));
    if (q_fix == '0) begin
      q_clamp = CW'(1);
    end else if (CW'(q_fix) > CW'(MAX_DELAY - 1)) begin
      q_clamp = CW'(MAX_DELAY - 1);
    end else begin
      q_clamp = CW'(q_fix);
    end
  end

endmodule

// File: design/sfd_lane.sv
`timescale 1ns / 1ps
module sfd_lane #(
  parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  sfd_pkg::gain_t                gain,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic signed [SAMPLE_BITS-1:0] dl,
  output logic signed [SAMPLE_BITS-1:0] w,
  output logic signed [SAMPLE_BITS-1:0] y
);

  localparam int SB = SAMPLE_BITS;
  localparam int VW = SB + 3;
  localparam logic signed [SB+15:0] HALF_FB  = 16384;
  localparam logic signed [SB+17:0] HALF_MIX = 16384;
  localparam logic signed [VW-1:0]  SAT_HI   = {4'b0000, {(SB-1){1'b1}}};
  localparam logic signed [VW-1:0]  SAT_LO   = {4'b1111, {(SB-1){1'b0}}};

  logic [sfd_pkg::WET_W-1:0] dry;
  logic signed [SB-1:0]      x2;
  logic signed [SB+15:0]     p_fb;
  logic signed [SB+16:0]     p_dry;
  logic signed [SB+16:0]     p_wet;
  logic signed [SB+15:0]     fb_rnd;
  logic signed [SB+17:0]     mix;
  logic signed [VW-1:0]      w_wide;
  logic signed [VW-1:0]      y_wide;

  function automatic logic signed [SB-1:0] sat(input logic signed [VW-1:0] v);
    logic signed [SB-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[SB-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SB-1:0];
    end else begin
      r = v[SB-1:0];
    end
    return r;
  endfunction

  assign dry = sfd_pkg::WET_W'(sfd_pkg::Q15_ONE - {1'b0, gain.wet});

  always_ff @(posedge clk) begin
    x2    <= x;
    p_fb  <= dl * $signed({1'b0, gain.fb});
    p_dry <= x * $signed({1'b0, dry});
    p_wet <= dl * $signed({1'b0, gain.wet});
  end

  // round half up: floor((v + 2^14) / 2^15)
  always_comb begin
    fb_rnd = (p_fb + HALF_FB) >>> 15;
    mix    = ((SB+18)'(p_dry) + (SB+18)'(p_wet) + HALF_MIX) >>> 15;
    w_wide = VW'(x2) + VW'($signed(fb_rnd[SB:0]));
    y_wide = VW'(mix[SB+2:0]);
  end

  always_ff @(posedge clk) begin
    w <= sat(w_wide);
    y <= sat(y_wide);
  end

endmodule

// File: design/sfd_merge.sv
`timescale 1ns / 1ps
module sfd_merge #(
  parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF,
  parameter int DEPTH = sfd_pkg::OUT_FIFO_DEPTH,
  localparam int TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int LW = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic signed [SAMPLE_BITS-1:0] left_y,
  input  logic signed [SAMPLE_BITS-1:0] right_y,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [TDATA_W-1:0]            m_axis_tdata,
  output logic [LW-1:0]                 level
);

  localparam int PW = $clog2(DEPTH);

  logic [2*SAMPLE_BITS-1:0] slots [DEPTH];
  logic [PW-1:0]            wr_ptr;
  logic [PW-1:0]            rd_ptr;
  logic                     pop;

  assign m_axis_tvalid = (level != '0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = TDATA_W'(slots[rd_ptr]);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= {right_y, left_y};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

// File: design/stereo_feedback_delay_unit.sv
// Stereo feedback echo.
// s_axis carries one stereo pair per request; m_axis returns one mixed pair per request,
// in order. cfg_we/cfg_index/cfg_data write the four setup registers (delay in ms,
// sample rate, feedback gain, wet mix); write them only while no request is in flight.
// After each write s_axis_tready stays low while the delay length is recomputed.
// An accepted pair passes the input registers, the lane multiply and round stages and
// the output queue on its way to m_axis. Throughput: one pair per cycle for delays of
// 2 samples or more while m_axis keeps up; at a delay of one sample a pair is held off
// while the pair just before it, the source of its echo, is in the multiply stage.
// The echo memory does one read and one write per cycle.
// Reset: settings return to 500 ms, 48 kHz, gain 0.5, wet 0.5, and a clearing pass
// zeroes the echo memory, one entry per cycle, holding s_axis_tready low over all
// MAX_DELAY entries (262144 by default). Setup writes are taken during the pass.
// Stall: an 8-entry output queue absorbs backpressure on m_axis; s_axis_tready drops
// when the queue plus the pairs in the pipeline would overflow it.
`timescale 1ns / 1ps
`include "stereo_feedback_delay_unit_defines.svh"
module stereo_feedback_delay_unit #(
  parameter int MAX_DELAY = sfd_pkg::MAX_DELAY_DEF,
  parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF,
  localparam int TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sfd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sfd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // left_sample, right_sample, zero pad
  input  logic [TDATA_W-1:0]                s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // left_out, right_out, zero pad
  output logic [TDATA_W-1:0]                m_axis_tdata
);

  localparam int AW       = $clog2(MAX_DELAY);
  localparam int SB       = SAMPLE_BITS;
  localparam int WORD_W   = 2 * SB;
  localparam int LANES    = 2;
  localparam int LW       = $clog2(sfd_pkg::OUT_FIFO_DEPTH + 1);
  localparam int SETTLE_W = $clog2(sfd_pkg::SETTLE_CYCLES + 1);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  state_t state;
  logic [AW-1:0] clr_cnt;

  logic [sfd_pkg::DELAY_MS_W-1:0] delay_ms;
  logic [sfd_pkg::RATE_W-1:0]     sample_rate_hz;
  logic [sfd_pkg::FB_W-1:0]       feedback_gain;
  logic [sfd_pkg::WET_W-1:0]      wet_mix;
  logic [SETTLE_W-1:0]            settle;
  sfd_pkg::gain_t                 gain;

  logic [AW-1:0] delay;
  logic [AW-1:0] wp;
  logic [AW-1:0] wp_next;
  logic [AW-1:0] rp;
  logic          accept;
  logic          hazard;
  logic [LW:0]   occ;
  logic [LW-1:0] level;

  logic          s1v, s2v, s3v;
  logic [AW-1:0] s1_rp, s1_wp, s2_wp, s3_wp;
  logic signed [SB-1:0] s1_x [LANES];
  logic signed [SB-1:0] dl   [LANES];
  logic signed [SB-1:0] w    [LANES];
  logic signed [SB-1:0] y    [LANES];

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] dword;
  logic              lw_v;
  logic [AW-1:0]     lw_addr;
  logic [WORD_W-1:0] lw_data;

  // setup registers; delay, feedback gain and wet mix are held to their legal ranges as they are written
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ms       <= sfd_pkg::DELAY_MS_RST;
      sample_rate_hz <= sfd_pkg::RATE_RST;
      feedback_gain  <= sfd_pkg::FB_RST;
      wet_mix        <= sfd_pkg::WET_RST;
      settle         <= SETTLE_W'(sfd_pkg::SETTLE_CYCLES);
    end else begin
      if (cfg_we) begin
        settle <= SETTLE_W'(sfd_pkg::SETTLE_CYCLES);
        case (cfg_index)
          sfd_pkg::CFG_DELAY_MS: begin
            if (cfg_data[sfd_pkg::DELAY_MS_W-1:0] < sfd_pkg::DELAY_MS_MIN) begin
              delay_ms <= sfd_pkg::DELAY_MS_MIN;
            end else if (cfg_data[sfd_pkg::DELAY_MS_W-1:0] > sfd_pkg::DELAY_MS_MAX) begin
              delay_ms <= sfd_pkg::DELAY_MS_MAX;
            end else begin
              delay_ms <= cfg_data[sfd_pkg::DELAY_MS_W-1:0];
            end
          end
          sfd_pkg::CFG_SAMPLE_RATE: begin
            sample_rate_hz <= cfg_data[sfd_pkg::RATE_W-1:0];
          end
          sfd_pkg::CFG_FEEDBACK: begin
            if (cfg_data[sfd_pkg::FB_W-1:0] > sfd_pkg::FB_MAX) begin
              feedback_gain <= sfd_pkg::FB_MAX;
            end else begin
              feedback_gain <= cfg_data[sfd_pkg::FB_W-1:0];
            end
          end
          sfd_pkg::CFG_WET_MIX: begin
            if (cfg_data[sfd_pkg::WET_W-1:0] > sfd_pkg::WET_MAX) begin
              wet_mix <= sfd_pkg::WET_MAX;
            end else begin
              wet_mix <= cfg_data[sfd_pkg::WET_W-1:0];
            end
          end
          default: begin
          end
        endcase
      end else if (settle != '0) begin
        settle <= settle - 1'b1;
      end
    end
  end

  assign gain = '{fb: feedback_gain, wet: wet_mix};

  sfd_delay_calc #(.MAX_DELAY(MAX_DELAY)) u_delay_calc (
    .clk            (clk),
    .delay_ms       (delay_ms),
    .sample_rate_hz (sample_rate_hz),
    .delay          (delay)
  );

  // clearing pass after reset, then run
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(MAX_DELAY - 1)) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  always_comb begin
    if (wp >= delay) begin
      rp = wp - delay;
    end else begin
      rp = AW'({1'b0, wp} + (AW+1)'(MAX_DELAY) - {1'b0, delay});
    end
    if (wp == AW'(MAX_DELAY - 1)) begin
      wp_next = '0;
    end else begin
      wp_next = wp + 1'b1;
    end
  end

  // hold off a request whose echo sample is still in the multiply stage
  assign hazard = s1v && (s1_wp == rp);
  assign occ    = (LW+1)'(level) + (LW+1)'(s1v) + (LW+1)'(s2v) + (LW+1)'(s3v);

  assign s_axis_tready = (state == ST_RUN) && (settle == '0) && !cfg_we && !hazard
                         && (occ < (LW+1)'(sfd_pkg::OUT_FIFO_DEPTH));
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      s1v <= 1'b0;
      s2v <= 1'b0;
      s3v <= 1'b0;
    end else begin
      if (accept) begin
        wp <= wp_next;
      end
      s1v <= accept;
      s2v <= s1v;
      s3v <= s2v;
    end
  end

  always_ff @(posedge clk) begin
    s1_rp   <= rp;
    s1_wp   <= wp;
    s2_wp   <= s1_wp;
    s3_wp   <= s2_wp;
    s1_x[0] <= s_axis_tdata[SB-1:0];
    s1_x[1] <= s_axis_tdata[WORD_W-1:SB];
  end

  assign ram_we    = (state == ST_CLEAR) || s3v;
  assign ram_waddr = (state == ST_CLEAR) ? clr_cnt : s3_wp;
  assign ram_wdata = (state == ST_CLEAR) ? '0 : {w[1], w[0]};

  sfd_ram #(.WIDTH(WORD_W), .DEPTH(MAX_DELAY)) u_echo_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rp),
    .rdata (ram_rdata)
  );

  // remember the write that lands on the same edge as a read
  always_ff @(posedge clk) begin
    if (rst) begin
      lw_v <= 1'b0;
    end else if (ram_we) begin
      lw_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      lw_addr <= ram_waddr;
      lw_data <= ram_wdata;
    end
  end

  // bypass writes not yet in the memory, newest first
  always_comb begin
    if (s3v && (s3_wp == s1_rp)) begin
      dword = {w[1], w[0]};
    end else if (lw_v && (lw_addr == s1_rp)) begin
      dword = lw_data;
    end else begin
      dword = ram_rdata;
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    assign dl[i] = dword[i*SB +: SB];

    sfd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
      .clk  (clk),
      .gain (gain),
      .x    (s1_x[i]),
      .dl   (dl[i]),
      .w    (w[i]),
      .y    (y[i])
    );
  end

  sfd_merge #(.SAMPLE_BITS(SAMPLE_BITS), .DEPTH(sfd_pkg::OUT_FIFO_DEPTH)) u_merge (
    .clk           (clk),
    .rst           (rst),
    .push          (s3v),
    .left_y        (y[0]),
    .right_y       (y[1]),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .level         (level)
  );

  `SFD_ASSERT_IMP(a_no_unready_echo, accept && s1v, rp != s1_wp, "echo read of a sample still in flight")
  `SFD_ASSERT_IMP(a_queue_bound, 1'b1, occ <= (LW+1)'(sfd_pkg::OUT_FIFO_DEPTH), "output queue overrun")
  `SFD_ASSERT_NXT(a_wp_step, accept && (wp != AW'(MAX_DELAY - 1)), wp == $past(wp) + 1'b1, "write pointer skipped")
  `SFD_ASSERT_IMP(a_clear_idle, state == ST_CLEAR, !s1v && !s2v && !s3v, "request in flight during clearing pass")

endmodule
